// File: hw/rtl/fba_pkg.sv
// Shared constants, types and helpers for the free bitmap allocator.
package fba_pkg;

  localparam int MapDepth = 4096;
  localparam int AddrW    = $clog2(MapDepth);
  localparam int CfgW     = 13;
  localparam int IdxW     = 15;

  typedef enum logic [2:0] {
    FN_SET       = 3'd0,
    FN_CLEAR     = 3'd1,
    FN_TEST      = 3'd2,
    FN_FIND      = 3'd3,
    FN_SET_ALL   = 3'd4,
    FN_CLEAR_ALL = 3'd5,
    FN_WR_BYTE   = 3'd6,
    FN_RD_BYTE   = 3'd7
  } func_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int k = 0; k <= 7; k++) begin
      if (!b[k]) pos = 3'(7 - k);
    end
    return pos;
  endfunction

endpackage

// File: hw/rtl/fba_ctrl.sv
// Sequencer: decodes requests, drives the map memory and builds results.
module fba_ctrl import fba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func_i,
  input  logic [IdxW-1:0]   bit_index_i,
  input  logic [7:0]        byte_data_i,
  input  logic [CfgW-1:0]   live_i,
  input  logic [7:0]        rdata_i,
  output mem_req_t          req_o,
  output logic              done_o,
  output logic              changed_o,
  output logic              bit_value_o,
  output logic              found_o,
  output logic [IdxW-1:0]   free_index_o,
  output logic [7:0]        byte_out_o,
  output logic              out_of_range_o
);

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_FIND,
    ST_FILL
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  func_e            func_q, func_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [7:0]       data_q, data_d;
  logic             done_q, done_d;
  logic             changed_q, changed_d;
  logic             bit_value_q, bit_value_d;
  logic             found_q, found_d;
  logic [IdxW-1:0]  free_index_q, free_index_d;
  logic [7:0]       byte_out_q, byte_out_d;
  logic             oor_q, oor_d;

  logic             bit_op;
  logic [AddrW-1:0] bit_byte;
  logic [7:0]       mask;
  logic             bit_oor;
  logic             raw_oor;
  logic [7:0]       new_byte;
  logic             ptr_last;
  logic             live_zero;

  assign bit_op    = (func_q == FN_SET) || (func_q == FN_CLEAR) || (func_q == FN_TEST);
  assign bit_byte  = idx_q[IdxW-1:3];
  assign mask      = 8'h80 >> idx_q[2:0];
  assign bit_oor   = {{(CfgW-AddrW){1'b0}}, bit_byte} >= live_i;
  assign raw_oor   = idx_q >= {{(IdxW-CfgW){1'b0}}, live_i};
  assign ptr_last  = ({{(CfgW-AddrW){1'b0}}, ptr_q} + CfgW'(1)) == live_i;
  assign live_zero = live_i == '0;

  always_comb begin
    new_byte = rdata_i;
    case (func_q)
      FN_SET:     new_byte = rdata_i | mask;
      FN_CLEAR:   new_byte = rdata_i & ~mask;
      FN_WR_BYTE: new_byte = data_q;
      default:    new_byte = rdata_i;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    func_d       = func_q;
    idx_d        = idx_q;
    data_d       = data_q;
    done_d       = 1'b0;
    changed_d    = 1'b0;
    bit_value_d  = 1'b0;
    found_d      = 1'b0;
    free_index_d = '0;
    byte_out_d   = '0;
    oor_d        = 1'b0;
    req_o        = '{we: 1'b0, addr: '0, wdata: '0};

    case (state_q)
      ST_CLR: begin
        req_o = '{we: 1'b1, addr: ptr_q, wdata: 8'h00};
        ptr_d = ptr_q + AddrW'(1);
        if (&ptr_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        case (func_e'(func_i))
          FN_SET, FN_CLEAR, FN_TEST: req_o.addr = bit_index_i[IdxW-1:3];
          FN_WR_BYTE, FN_RD_BYTE:    req_o.addr = bit_index_i[AddrW-1:0];
          default:                   req_o.addr = '0;
        endcase
        if (start) begin
          func_d = func_e'(func_i);
          idx_d  = bit_index_i;
          data_d = byte_data_i;
          ptr_d  = '0;
          case (func_e'(func_i))
            FN_FIND:                 state_d = live_zero ? ST_EXEC : ST_FIND;
            FN_SET_ALL, FN_CLEAR_ALL: state_d = live_zero ? ST_EXEC : ST_FILL;
            default:                 state_d = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (bit_op) begin
          req_o.addr  = bit_byte;
          req_o.wdata = new_byte;
          if (bit_oor) begin
            oor_d = 1'b1;
          end else begin
            req_o.we    = new_byte != rdata_i;
            changed_d   = new_byte != rdata_i;
            bit_value_d = (func_q == FN_TEST) && ((rdata_i & mask) != 8'h00);
          end
        end else if ((func_q == FN_WR_BYTE) || (func_q == FN_RD_BYTE)) begin
          req_o.addr  = idx_q[AddrW-1:0];
          req_o.wdata = new_byte;
          if (raw_oor) begin
            oor_d = 1'b1;
          end else if (func_q == FN_WR_BYTE) begin
            req_o.we = 1'b1;
          end else begin
            byte_out_d = rdata_i;
          end
        end
      end
      ST_FIND: begin
        req_o.addr = ptr_q + AddrW'(1);
        if (rdata_i != 8'hFF) begin
          state_d      = ST_IDLE;
          done_d       = 1'b1;
          found_d      = 1'b1;
          free_index_d = IdxW'({ptr_q, first_zero(rdata_i)});
        end else if (ptr_last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end
      ST_FILL: begin
        req_o = '{we: 1'b1, addr: ptr_q,
                  wdata: (func_q == FN_SET_ALL) ? 8'hFF : 8'h00};
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      ptr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    idx_q        <= idx_d;
    data_q       <= data_d;
    changed_q    <= changed_d;
    bit_value_q  <= bit_value_d;
    found_q      <= found_d;
    free_index_q <= free_index_d;
    byte_out_q   <= byte_out_d;
    oor_q        <= oor_d;
  end

  assign busy           = state_q != ST_IDLE;
  assign done_o         = done_q;
  assign changed_o      = changed_q;
  assign bit_value_o    = bit_value_q;
  assign found_o        = found_q;
  assign free_index_o   = free_index_q;
  assign byte_out_o     = byte_out_q;
  assign out_of_range_o = oor_q;

endmodule

// File: hw/rtl/free_bitmap_allocator_core.sv
// Top level of the free bitmap allocator: map memory, size register, sequencer.
//
// A transaction is taken when start is high and busy is low; its result shows
// for one cycle with done_o and cannot be held off. Set, clear, test and raw
// byte access read the addressed byte, then modify and write it back in the
// execute state (a bit op only when the byte changes, a raw read never). Find
// free reads bytes from byte 0 up to the first clear bit or the last byte in
// use; set all and clear all write every byte in use; both go through the
// single map memory port, one byte per cycle, with bytes_in_use capped at
// 4096. With zero bytes in use they touch no byte. After reset the map is swept
// to zero, all 4096 bytes, with busy high; the size register can be written meanwhile.
module free_bitmap_allocator_core import fba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [2:0]      func_i,
  input  logic [IdxW-1:0] bit_index_i,
  input  logic [7:0]      byte_data_i,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  output logic            done_o,
  output logic            changed_o,
  output logic            bit_value_o,
  output logic            found_o,
  output logic [IdxW-1:0] free_index_o,
  output logic [7:0]      byte_out_o,
  output logic            out_of_range_o
);

  logic [7:0]      map_q [MapDepth];
  logic [7:0]      rdata_q;
  logic [CfgW-1:0] bytes_q;
  logic [CfgW-1:0] live;
  mem_req_t        req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q <= CfgW'(MapDepth);
    end else if (cfg_we_i) begin
      bytes_q <= cfg_wdata_i;
    end
  end

  assign live = (bytes_q > CfgW'(MapDepth)) ? CfgW'(MapDepth) : bytes_q;

  always_ff @(posedge clk_i) begin
    if (req.we) map_q[req.addr] <= req.wdata;
    rdata_q <= map_q[req.addr];
  end

  fba_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .bit_index_i    (bit_index_i),
    .byte_data_i    (byte_data_i),
    .live_i         (live),
    .rdata_i        (rdata_q),
    .req_o          (req),
    .done_o         (done_o),
    .changed_o      (changed_o),
    .bit_value_o    (bit_value_o),
    .found_o        (found_o),
    .free_index_o   (free_index_o),
    .byte_out_o     (byte_out_o),
    .out_of_range_o (out_of_range_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted transaction not held");

  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_of_range_o) |-> (!changed_o && !found_o && !bit_value_o))
    else $error("out of range transaction reported an effect");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !req.we) else $error("map written while idle");

endmodule

// File: tb/free_bitmap_allocator_core_test.sv
// Self-checking testbench for the free bitmap allocator core.
`timescale 1ns / 1ps

module free_bitmap_allocator_core_test;
  import fba_pkg::*;

  typedef struct packed {
    func_e            fn;
    logic [IdxW-1:0]  idx;
    logic [7:0]       data;
  } alloc_req_t;

  typedef struct packed {
    logic             changed;
    logic             bit_value;
    logic             found;
    logic [IdxW-1:0]  free_index;
    logic [7:0]       byte_out;
    logic             oor;
  } alloc_result_t;

  localparam int StallLimit = 20000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  logic [2:0]      func_i      = FN_SET;
  logic [IdxW-1:0] bit_index_i = '0;
  logic [7:0]      byte_data_i = '0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            done_o;
  logic            changed_o;
  logic            bit_value_o;
  logic            found_o;
  logic [IdxW-1:0] free_index_o;
  logic [7:0]      byte_out_o;
  logic            out_of_range_o;

  free_bitmap_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .bit_index_i    (bit_index_i),
    .byte_data_i    (byte_data_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .changed_o      (changed_o),
    .bit_value_o    (bit_value_o),
    .found_o        (found_o),
    .free_index_o   (free_index_o),
    .byte_out_o     (byte_out_o),
    .out_of_range_o (out_of_range_o)
  );

  initial forever #5 clk_i = ~clk_i;

  logic [7:0]      map_model [MapDepth];
  logic [CfgW-1:0] size_reg = CfgW'(MapDepth);

  alloc_req_t    pending_q [$];
  alloc_result_t expect_q  [$];

  int idle_pct  = 24;
  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_found   = 0;
  int n_oor     = 0;
  int n_changed = 0;
  int n_sizes   = 1;
  int stall_cnt = 0;

  initial begin
    for (int i = 0; i < MapDepth; i++) map_model[i] = 8'h00;
  end

  function automatic int live_bytes();
    return (size_reg > MapDepth) ? MapDepth : int'(size_reg);
  endfunction

  function automatic alloc_result_t predict_request(func_e fn, logic [IdxW-1:0] idx,
                                                    logic [7:0] data);
    alloc_result_t r;
    int            live;
    int            bnum;
    int            bitpos;
    logic [7:0]    mask;
    logic [7:0]    old_b;
    r    = '0;
    live = live_bytes();
    case (fn)
      FN_SET, FN_CLEAR, FN_TEST: begin
        bnum = int'(idx >> 3);
        mask = 8'h80 >> idx[2:0];
        if (bnum >= live) begin
          r.oor = 1'b1;
        end else begin
          old_b = map_model[bnum];
          if (fn == FN_SET) map_model[bnum] = old_b | mask;
          else if (fn == FN_CLEAR) map_model[bnum] = old_b & ~mask;
          else r.bit_value = |(old_b & mask);
          r.changed = (map_model[bnum] != old_b);
        end
      end
      FN_FIND: begin
        for (int i = 0; i < live && !r.found; i++) begin
          if (map_model[i] != 8'hFF) begin
            bitpos = i * 8;
            mask   = 8'h80;
            while ((map_model[i] & mask) != 8'h00) begin
              mask   = mask >> 1;
              bitpos = bitpos + 1;
            end
            r.found      = 1'b1;
            r.free_index = bitpos[IdxW-1:0];
          end
        end
      end
      FN_SET_ALL: for (int i = 0; i < live; i++) map_model[i] = 8'hFF;
      FN_CLEAR_ALL: for (int i = 0; i < live; i++) map_model[i] = 8'h00;
      default: begin
        if (int'(idx) >= live) r.oor = 1'b1;
        else if (fn == FN_WR_BYTE) map_model[idx] = data;
        else r.byte_out = map_model[idx];
      end
    endcase
    return r;
  endfunction

  function automatic alloc_req_t random_request(int live);
    alloc_req_t q;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 25) q.fn = FN_SET;
    else if (pick < 45) q.fn = FN_CLEAR;
    else if (pick < 60) q.fn = FN_TEST;
    else if (pick < 74) q.fn = FN_FIND;
    else if (pick < 82) q.fn = FN_WR_BYTE;
    else if (pick < 90) q.fn = FN_RD_BYTE;
    else if (pick < 95) q.fn = FN_SET_ALL;
    else q.fn = FN_CLEAR_ALL;
    q.data = 8'($urandom_range(255));
    if (live > 0 && $urandom_range(99) < 85) begin
      if (q.fn == FN_WR_BYTE || q.fn == FN_RD_BYTE) q.idx = IdxW'($urandom_range(live - 1));
      else q.idx = IdxW'($urandom_range(live * 8 - 1));
    end else begin
      q.idx = IdxW'($urandom_range(32767));
    end
    return q;
  endfunction

  task automatic queue_req(func_e fn, int idx, int data);
    alloc_req_t q;
    q.fn   = fn;
    q.idx  = IdxW'(idx);
    q.data = 8'(data);
    pending_q.push_back(q);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || start || busy || expect_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_size(int v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CfgW'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_reg = CfgW'(v);
    n_sizes++;
  endtask

  task automatic run_random(int sz, int count);
    int live;
    write_size(sz);
    live = (sz > MapDepth) ? MapDepth : sz;
    for (int i = 0; i < count; i++) pending_q.push_back(random_request(live));
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    alloc_req_t    nxt;
    alloc_result_t r;
    logic          slot_free;
    if (!rst_ni) begin
      start       <= 1'b0;
      func_i      <= FN_SET;
      bit_index_i <= '0;
      byte_data_i <= '0;
    end else begin
      slot_free = !start || !busy;
      if (start && !busy) begin
        r = predict_request(func_e'(func_i), bit_index_i, byte_data_i);
        expect_q.push_back(r);
        n_sent++;
        if (r.found) n_found++;
        if (r.oor) n_oor++;
        if (r.changed) n_changed++;
      end
      if (slot_free) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_q.pop_front();
          start       <= 1'b1;
          func_i      <= nxt.fn;
          bit_index_i <= nxt.idx;
          byte_data_i <= nxt.data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && done_o) begin
      got.changed    = changed_o;
      got.bit_value  = bit_value_o;
      got.found      = found_o;
      got.free_index = free_index_o;
      got.byte_out   = byte_out_o;
      got.oor        = out_of_range_o;
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with no transaction pending: %p", got);
      end else begin
        want = expect_q.pop_front();
        n_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: result %0d: expected chg=%0b bit=%0b fnd=%0b idx=%0d byte=%02h oor=%0b, got chg=%0b bit=%0b fnd=%0b idx=%0d byte=%02h oor=%0b",
                     n_checked, want.changed, want.bit_value, want.found, want.free_index,
                     want.byte_out, want.oor, got.changed, got.bit_value, got.found,
                     got.free_index, got.byte_out, got.oor);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || done_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("ERROR: no transaction for %0d cycles", StallLimit);
      $display("free_bitmap_allocator_core_test: done, errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(FN_FIND, 0, 0);
    queue_req(FN_SET, 0, 0);
    queue_req(FN_SET, 0, 255);
    queue_req(FN_TEST, 0, 0);
    queue_req(FN_CLEAR, 0, 0);
    queue_req(FN_CLEAR, 0, 0);
    queue_req(FN_SET, 32767, 0);
    queue_req(FN_TEST, 32767, 0);
    queue_req(FN_RD_BYTE, 4095, 0);
    queue_req(FN_WR_BYTE, 0, 8'hAA);
    queue_req(FN_RD_BYTE, 0, 0);
    queue_req(FN_FIND, 0, 0);
    queue_req(FN_WR_BYTE, 4096, 8'h55);
    queue_req(FN_SET_ALL, 0, 0);
    queue_req(FN_FIND, 0, 0);
    queue_req(FN_TEST, 12345, 0);
    queue_req(FN_CLEAR_ALL, 32767, 255);
    queue_req(FN_FIND, 0, 0);
    wait_drained();

    write_size(0);
    queue_req(FN_SET, 0, 0);
    queue_req(FN_FIND, 0, 0);
    queue_req(FN_SET_ALL, 0, 0);
    queue_req(FN_RD_BYTE, 0, 0);
    wait_drained();

    write_size(1);
    queue_req(FN_WR_BYTE, 0, 8'hFE);
    queue_req(FN_FIND, 0, 0);
    queue_req(FN_SET, 7, 0);
    queue_req(FN_FIND, 0, 0);
    queue_req(FN_SET, 8, 0);
    wait_drained();

    write_size(8191);
    queue_req(FN_RD_BYTE, 4095, 0);
    queue_req(FN_CLEAR, 32767, 0);
    wait_drained();

    run_random(3, 50);
    run_random(16, 50);
    run_random(1, 45);
    run_random(4096, 20);
    idle_pct = 0;
    run_random(2, 60);
    idle_pct = 24;
    run_random(0, 30);
    run_random(5, 50);
    run_random(8191, 20);
    run_random(12, 50);
    run_random($urandom_range(8191, 17), 20);
    run_random(8, 50);
    run_random(4, 50);

    repeat (10) @(posedge clk_i);
    $display("%0d transactions sent, %0d results checked across %0d map sizes",
             n_sent, n_checked, n_sizes);
    $display("free bit found %0d times, %0d out of range, %0d bit changes",
             n_found, n_oor, n_changed);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("free_bitmap_allocator_core_test: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expect_q.size());
      $display("free_bitmap_allocator_core_test: done, errors");
    end
    $finish;
  end

endmodule

// File: free_bitmap_allocator_core.f
hw/rtl/fba_pkg.sv
hw/rtl/fba_ctrl.sv
hw/rtl/free_bitmap_allocator_core.sv
tb/free_bitmap_allocator_core_test.sv
